>>> hdl/ntcof_pkg.sv
package ntcof_pkg;

   // Fixed field widths
   localparam int ADC_IN_W = 10;
   localparam int TEMP_W   = 16;
   localparam int WIN_W    = 14;

   localparam logic [WIN_W-1:0] WIN_RESET = 14'd200;

   // Result clamp, centidegrees C
   localparam int TEMP_LOW  = -27215;
   localparam int TEMP_HIGH = 3000;
   localparam int KELVIN_OFS = 27215;

   // Offset that keeps the average numerator positive
   localparam int AVG_OFS = 40000;

   // Depth of the queues between the stages and at the result side
   localparam int QUEUE_DEPTH = 2;

   // Beta-equation constants in fixed point
   localparam logic [63:0] LN2_Q24   = 64'd11629080;
   localparam logic [63:0] NUM_CK    = 64'd21869022239000;
   localparam logic [63:0] DEN_BASE  = 64'd733490600;
   localparam logic [63:0] DEN_SLOPE = 64'd29815000;
   localparam logic [63:0] R_SERIES  = 64'd19305;
   localparam logic [63:0] V_REF_MV  = 64'd9934;
   localparam logic [63:0] V_SUP     = 64'd33000;
   localparam logic [63:0] R_NOM     = 64'd10000;

   typedef logic signed [TEMP_W-1:0] temp_type;

   typedef struct packed {
      temp_type temperature;
      logic     from_average;
      logic     sample_accepted;
   } rsp_type;

   // log2 of v > 0, Q24 (elaboration only)
   function automatic logic [63:0] log2_q24(input logic [63:0] v);
      logic [63:0] m;
      logic [63:0] r;
      int          k;
      k = 0;
      for (int j = 0; j < 63; j++) begin
         if ((v >> (j + 1)) != 64'd0) k = j + 1;
      end
      if (k >= 31) m = v >> (k - 31);
      else m = v << (31 - k);
      r = 64'(k) << 24;
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            r = r | (64'd1 << i);
         end
      end
      return r;
   endfunction

   // Restoring division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      q   = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem  = rem - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // ADC code to centidegrees C, used to build the lookup ROM
   function automatic temp_type ntc_convert(input int unsigned a, input int unsigned adc_bits);
      logic [63:0] fs;
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] ln_n;
      logic [63:0] ln_d;
      logic [63:0] mag;
      logic [63:0] lnq;
      logic [63:0] den;
      logic [63:0] ck;
      longint      t;
      if (a == 0) return temp_type'(TEMP_LOW);
      fs   = 64'd1 << adc_bits;
      n    = R_SERIES * V_REF_MV * 64'(a);
      d    = R_NOM * (V_SUP * fs - V_REF_MV * 64'(a));
      ln_n = log2_q24(n);
      ln_d = log2_q24(d);
      mag  = (ln_d > ln_n) ? (ln_d - ln_n) : 64'd0;
      lnq  = (mag * LN2_Q24 + (64'd1 << 23)) >> 24;
      den  = DEN_BASE * 64'd256 + ((DEN_SLOPE * lnq) >> 16);
      ck   = udiv64(NUM_CK * 64'd256 + (den >> 1), den);
      t    = longint'(ck) - longint'(KELVIN_OFS);
      if (t < longint'(TEMP_LOW)) t = longint'(TEMP_LOW);
      if (t > longint'(TEMP_HIGH)) t = longint'(TEMP_HIGH);
      return temp_type'(t);
   endfunction

endpackage

>>> hdl/ntcof_queue.sv
module ntcof_queue import ntcof_pkg::*; #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> hdl/ntcof_front.sv
module ntcof_front import ntcof_pkg::*; #(
   parameter int ADC_BITS = 10
) (
   input  logic [ADC_IN_W-1:0] adc_sample,
   output temp_type            temperature
);

   localparam int ROM_DEPTH = 2 ** ADC_BITS;

   temp_type            rom [ROM_DEPTH];
   logic [ADC_BITS-1:0] addr;

   // Conversion table, built at elaboration
   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
      localparam temp_type ENTRY = ntc_convert(g, ADC_BITS);
      assign rom[g] = ENTRY;
   end

   // Only the low ADC_BITS bits of the sample count
   assign addr        = ADC_BITS'(adc_sample);
   assign temperature = rom[addr];

endmodule

>>> hdl/ntcof_back.sv
module ntcof_back import ntcof_pkg::*; #(
   parameter int HISTORY_DEPTH = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [WIN_W-1:0] csr_wr_data,
   input  logic             mid_empty,
   input  temp_type         mid_temp,
   output logic             mid_pop,
   input  logic             out_full,
   output logic             out_push,
   output rsp_type          out_data
);

   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = TEMP_W + $clog2(HISTORY_DEPTH);
   localparam int CMP_W  = SUM_W + 2;
   localparam int X_W    = 18 + $clog2(HISTORY_DEPTH);
   localparam int DIV    = 2 * HISTORY_DEPTH;
   localparam int DIV_SH = $clog2(DIV);
   localparam int K_SH   = X_W + DIV_SH;
   localparam int R_W    = X_W + 1;
   localparam int Q_W    = R_W - DIV_SH;
   localparam int P_W    = X_W + R_W;
   localparam longint unsigned RECIP = ((longint'(1) << K_SH) + DIV - 1) / DIV;
   localparam logic [R_W-1:0] RECIP_V = R_W'(RECIP);
   localparam logic [X_W-1:0] OFS_V   = X_W'(HISTORY_DEPTH * AVG_OFS);

   logic [WIN_W-1:0]        window_ff, window_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   temp_type                hist_ff [HISTORY_DEPTH];
   temp_type                hist_in [HISTORY_DEPTH];
   temp_type                shift_src [HISTORY_DEPTH];

   logic                    go, filling, in_window;
   logic [X_W-1:0]          shifted, x_val;
   logic [P_W-1:0]          prod;
   logic [Q_W-1:0]          quot;
   temp_type                avg;
   logic signed [CMP_W-1:0] nt, nw, lo_bound, hi_bound;

   assign go       = !mid_empty && !out_full;
   assign mid_pop  = go;
   assign out_push = go;
   assign filling  = (fill_ff < CNT_W'(HISTORY_DEPTH));

   // Rounded average: floor((2*sum + N) / 2N) via exact reciprocal multiply
   assign shifted = X_W'(sum_ff) + OFS_V;
   assign x_val   = {shifted[X_W-2:0], 1'b0} + X_W'(HISTORY_DEPTH);
   assign prod    = P_W'(x_val) * P_W'(RECIP_V);
   assign quot    = prod[K_SH +: Q_W];
   assign avg     = TEMP_W'($signed({1'b0, quot}) - AVG_OFS);

   // Window test scaled by N, strict on both sides
   assign nt        = CMP_W'(mid_temp) * CMP_W'(HISTORY_DEPTH);
   assign nw        = CMP_W'(window_ff) * CMP_W'(HISTORY_DEPTH);
   assign lo_bound  = CMP_W'(sum_ff) - nw;
   assign hi_bound  = CMP_W'(sum_ff) + nw;
   assign in_window = (nt > lo_bound) && (nt < hi_bound);

   assign out_data.temperature     = filling ? mid_temp : avg;
   assign out_data.from_average    = !filling;
   assign out_data.sample_accepted = filling || in_window;

   for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_src
      if (g == HISTORY_DEPTH - 1) begin : g_last
         assign shift_src[g] = mid_temp;
      end else begin : g_mid
         assign shift_src[g] = hist_ff[g + 1];
      end
   end

   always_comb begin
      window_in = csr_wr_en ? csr_wr_data : window_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      hist_in   = hist_ff;
      if (go) begin
         if (filling) begin
            fill_in = fill_ff + 1'b1;
            sum_in  = sum_ff + SUM_W'(mid_temp);
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               if (fill_ff == CNT_W'(i)) hist_in[i] = mid_temp;
            end
         end else if (in_window) begin
            sum_in = sum_ff - SUM_W'(hist_ff[0]) + SUM_W'(mid_temp);
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               hist_in[i] = shift_src[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_RESET;
         fill_ff   <= '0;
         sum_ff    <= '0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
      end
   end

   // Entries are read only after they have been written
   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
   end

endmodule

>>> hdl/ntc_temperature_outlier_filter.sv
// NTC thermistor temperature with moving-average outlier rejection.
//
// Input queue (req_): drive req_adc_sample with req_push; a transfer happens
// on a clock edge with req_push high and req_full low. Result queue (rsp_):
// while rsp_empty is low, the oldest result sits on rsp_temperature_out,
// rsp_from_average and rsp_sample_accepted; raise rsp_pop to take it.
// Config: csr_wr_en with csr_wr_data writes the acceptance half width
// (centidegrees); write it only while the block is idle.
//
// A pushed sample waits in the middle queue, then the combinational history/
// average stage puts it in the result queue, one sample per cycle while the
// result queue is not full. The lookup writes straight into a 2-entry queue.
// Reset empties both queues, clears the history fill count and running sum,
// and loads the window with 200. When the consumer stops popping, the result
// queue fills, the history stage halts, then the middle queue fills and
// req_full rises; nothing is dropped.
module ntc_temperature_outlier_filter import ntcof_pkg::*; #(
   parameter int HISTORY_DEPTH = 5,
   parameter int ADC_BITS      = 10
) (
   input  logic                clock,
   input  logic                reset,
   // input queue
   input  logic                req_push,
   output logic                req_full,
   input  logic [ADC_IN_W-1:0] req_adc_sample,
   // result queue
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output temp_type            rsp_temperature_out,
   output logic                rsp_from_average,
   output logic                rsp_sample_accepted,
   // config
   input  logic                csr_wr_en,
   input  logic [WIN_W-1:0]    csr_wr_data
);

   localparam int RSP_W = $bits(rsp_type);

   temp_type             rom_temp;   // converted sample from the ROM
   temp_type             mid_temp;   // head of the middle queue
   logic [TEMP_W-1:0]    mid_head;
   logic                 mid_empty, mid_pop;
   logic                 out_full, out_push;
   rsp_type              out_data, out_head;
   logic [RSP_W-1:0]     out_head_bits;

   // Front: ADC code to centidegrees
   ntcof_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .adc_sample  (req_adc_sample),
      .temperature (rom_temp)
   );

   // Decouples the lookup from the history stage
   ntcof_queue #(
      .WIDTH (TEMP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (rom_temp),
      .full      (req_full),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .head      (mid_head)
   );

   assign mid_temp = temp_type'(mid_head);

   // Back: history, running sum, average and window check
   ntcof_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mid_empty   (mid_empty),
      .mid_temp    (mid_temp),
      .mid_pop     (mid_pop),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_data    (out_data)
   );

   // Result queue; holds finished results while the consumer stalls
   ntcof_queue #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (out_head_bits)
   );

   assign out_head            = rsp_type'(out_head_bits);
   assign rsp_temperature_out = out_head.temperature;
   assign rsp_from_average    = out_head.from_average;
   assign rsp_sample_accepted = out_head.sample_accepted;

endmodule

>>> tb/ntc_temperature_outlier_filter_test.sv
module ntc_temperature_outlier_filter_test;
   import ntcof_pkg::*;

   // Block configuration under test (matches the instance defaults)
   localparam int DEPTH     = 5;
   localparam int ADC_WIDTH = 10;

   // Run control
   localparam int CYCLE_LIMIT   = 400000;  // watchdog, far above the slowest correct run
   localparam int HOLD_CYCLES   = 250;     // receiver hold-off for the pressure test
   localparam int REPORT_LIMIT  = 10;      // mismatches printed in full
   localparam int SETTLE_CYCLES = 4;       // quiet margin after the results drain
   localparam int RANDOM_ITEMS  = 1500;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [ADC_IN_W-1:0] req_adc_sample = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   temp_type            rsp_temperature_out;
   logic                rsp_from_average;
   logic                rsp_sample_accepted;
   logic                csr_wr_en = 1'b0;
   logic [WIN_W-1:0]    csr_wr_data = '0;

   ntc_temperature_outlier_filter #(
      .HISTORY_DEPTH (DEPTH),
      .ADC_BITS      (ADC_WIDTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_adc_sample      (req_adc_sample),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_temperature_out (rsp_temperature_out),
      .rsp_from_average    (rsp_from_average),
      .rsp_sample_accepted (rsp_sample_accepted),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow of the filter state, updated at each input transfer
   // ---------------------------------------------------------------
   temp_type       hist_entries[$];   // oldest first
   int             hist_count;
   int             hist_sum;
   int unsigned    window_cfg;
   rsp_type        pending_readings[$];  // predicted results, oldest first

   // Stimulus knobs, percent of cycles each side sits idle
   int unsigned    req_idle_pct = 30;
   int unsigned    pop_idle_pct = 30;
   bit             hold_request = 1'b0;
   int             center_adc = 512;

   // Bookkeeping
   int             error_count = 0;
   int             sent_count = 0;
   int             checked_count = 0;
   int             avg_count = 0;
   int             accepted_count = 0;
   int             full_stall_cycles = 0;
   int             window_writes = 0;
   int             cycle_count = 0;

   // Q24 base-2 log: normalize to Q31 by truncation, then square-and-compare
   function automatic logic [63:0] log2_fix24(input logic [63:0] v);
      logic [63:0] mant;
      logic [63:0] acc;
      int          msb;
      msb = 0;
      for (int b = 63; b >= 0; b--) begin
         if (v[b]) begin
            msb = b;
            break;
         end
      end
      mant = (msb >= 31) ? (v >> (msb - 31)) : (v << (31 - msb));
      acc  = 64'(msb) << 24;
      for (int i = 23; i >= 0; i--) begin
         mant = (mant * mant) >> 31;
         if (mant >= 64'h1_0000_0000) begin
            mant = mant >> 1;
            acc[i] = 1'b1;
         end
      end
      return acc;
   endfunction

   // Raw divider reading to centidegrees C via the fixed-point beta equation
   function automatic temp_type thermistor_centideg(input logic [ADC_IN_W-1:0] code);
      logic [63:0] full_scale;
      logic [63:0] numer;
      logic [63:0] denom;
      logic [63:0] lg_num;
      logic [63:0] lg_den;
      logic [63:0] ln_mag;
      logic [63:0] ln_q24;
      logic [63:0] beta_den;
      logic [63:0] centikelvin;
      longint      deg;
      if (code == '0) return temp_type'(TEMP_LOW);   // zero reading: 0 K limit
      full_scale  = 64'd1 << ADC_WIDTH;
      numer       = R_SERIES * V_REF_MV * 64'(code);
      denom       = R_NOM * (V_SUP * full_scale - V_REF_MV * 64'(code));
      lg_num      = log2_fix24(numer);
      lg_den      = log2_fix24(denom);
      ln_mag      = (lg_den > lg_num) ? (lg_den - lg_num) : 64'd0;
      ln_q24      = (ln_mag * LN2_Q24 + (64'd1 << 23)) >> 24;
      beta_den    = DEN_BASE * 64'd256 + ((DEN_SLOPE * ln_q24) >> 16);
      centikelvin = (NUM_CK * 64'd256 + beta_den / 64'd2) / beta_den;
      deg         = longint'(centikelvin) - longint'(KELVIN_OFS);
      if (deg < longint'(TEMP_LOW))  deg = longint'(TEMP_LOW);
      if (deg > longint'(TEMP_HIGH)) deg = longint'(TEMP_HIGH);
      return temp_type'(deg);
   endfunction

   // Advance the shadow history by one sample and produce its result
   function automatic rsp_type predict_reading(input logic [ADC_IN_W-1:0] code);
      rsp_type  res;
      temp_type t;
      longint   s;
      longint   w;
      t   = thermistor_centideg(code);
      res = '0;
      if (hist_count < DEPTH) begin
         // fill phase: store and pass through
         hist_entries.push_back(t);
         hist_sum += int'(t);
         hist_count++;
         res.temperature     = t;
         res.sample_accepted = 1'b1;
      end else begin
         s = longint'(hist_sum);
         w = longint'(window_cfg);
         res.temperature  = temp_type'((2 * (s + DEPTH * AVG_OFS) + DEPTH) / (2 * DEPTH)
                                       - AVG_OFS);
         res.from_average = 1'b1;
         // strict window around the exact average
         if (DEPTH * longint'(t) > s - DEPTH * w && DEPTH * longint'(t) < s + DEPTH * w) begin
            hist_sum -= int'(hist_entries.pop_front());
            hist_entries.push_back(t);
            hist_sum += int'(t);
            res.sample_accepted = 1'b1;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Sender: one input transfer. req_push is left high on return so
   // back-to-back items never see a low/high pair in one step.
   // ---------------------------------------------------------------
   task automatic send_sample(input logic [ADC_IN_W-1:0] code);
      while ($urandom_range(99) < req_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_adc_sample <= code;
      @(posedge clock);
      while (req_full) begin
         full_stall_cycles++;
         @(posedge clock);
      end
      pending_readings.push_back(predict_reading(code));
      sent_count++;
   endtask

   // Drop the input, let every result drain, then a few quiet cycles
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_accept_window(input logic [WIN_W-1:0] w);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      window_cfg = 32'(w);
      window_writes++;
   endtask

   // Mostly samples near a drifting center so the window test gets exercised,
   // the rest spread over the full code range
   function automatic logic [ADC_IN_W-1:0] pick_sample();
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 70) begin
         v = center_adc + int'($urandom_range(12)) - 6;
         if (v < 0)    v = 0;
         if (v > 1023) v = 1023;
         if ($urandom_range(9) == 0) center_adc = v;   // slow drift
      end else if (r < 95) begin
         v = $urandom_range(1023);
      end else begin
         center_adc = $urandom_range(1023);
         v = center_adc;
      end
      return ADC_IN_W'(v);
   endfunction

   // ---------------------------------------------------------------
   // Receiver: random pops, with a long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
         @(posedge clock);
      end
   end

   // Checker: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         checked_count++;
         if (pending_readings.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result: temp %0d avg %0b acc %0b",
                        rsp_temperature_out, rsp_from_average, rsp_sample_accepted);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_from_average)    avg_count++;
            if (rsp_sample_accepted) accepted_count++;
            if (rsp_temperature_out !== want.temperature ||
                rsp_from_average !== want.from_average ||
                rsp_sample_accepted !== want.sample_accepted) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("mismatch #%0d: exp %0d avg %0b acc %0b, got %0d avg %0b acc %0b",
                           checked_count, want.temperature, want.from_average,
                           want.sample_accepted, rsp_temperature_out,
                           rsp_from_average, rsp_sample_accepted);
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ntc_temperature_outlier_filter verification failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Fill phase with the zero reading and full-scale code, then averages
   task automatic test_fill_and_extremes();
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'd512);
      send_sample(10'd512);
      send_sample(10'd512);
      // history now full: averaged output from here on
      send_sample(10'd512);
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'd1);
   endtask

   // Zero window, window above the nominal range, both nominal extremes
   task automatic test_window_extremes();
      set_accept_window(14'd0);          // nothing gets in once full
      send_sample(10'd512);
      send_sample(10'd512);
      set_accept_window(14'd16383);      // widest: flush history to one value
      repeat (5) send_sample(10'd512);
      send_sample(10'd0);
      set_accept_window(WIN_RESET);
      send_sample(10'd512);
      send_sample(10'd513);
      send_sample(10'd511);
      send_sample(10'd1023);
      set_accept_window(14'd10000);
      send_sample(10'd1023);
      send_sample(10'd0);
      set_accept_window(14'd1);
      send_sample(10'd512);
      set_accept_window(WIN_RESET);
   endtask

   // Long stretch with both sides running flat out
   task automatic test_back_to_back();
      req_idle_pct = 0;
      pop_idle_pct = 0;
      repeat (300) send_sample(pick_sample());
      req_idle_pct = 30;
      pop_idle_pct = 30;
   endtask

   // Receiver holds off while the sender keeps offering: block fills, req_full rises
   task automatic test_result_backpressure();
      req_idle_pct = 0;
      hold_request = 1'b1;
      repeat (60) send_sample(pick_sample());
      req_idle_pct = 30;
   endtask

   // Random traffic over a rotation of window settings
   task automatic test_random_mix();
      int remaining;
      int phase_len;
      int pick;
      logic [WIN_W-1:0] w;
      remaining = RANDOM_ITEMS;
      while (remaining > 0) begin
         pick = $urandom_range(8);
         case (pick)
            0:       w = 14'd0;
            1:       w = 14'd1;
            2:       w = 14'd25;
            3:       w = WIN_RESET;
            4:       w = 14'd800;
            5:       w = 14'd3000;
            6:       w = 14'd10000;
            7:       w = 14'd16383;
            default: w = WIN_W'($urandom_range(16383));
         endcase
         set_accept_window(w);
         center_adc = $urandom_range(1023);
         phase_len = $urandom_range(100, 300);
         if (phase_len > remaining) phase_len = remaining;
         repeat (phase_len) send_sample(pick_sample());
         remaining -= phase_len;
      end
   endtask

   initial begin
      hist_count = 0;
      hist_sum   = 0;
      window_cfg = 32'(WIN_RESET);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_and_extremes();
      test_window_extremes();
      test_back_to_back();
      test_result_backpressure();
      test_random_mix();

      wait_idle();
      repeat (20) @(posedge clock);
      if (pending_readings.size() != 0) error_count++;

      $display("%0d samples sent, %0d results checked (%0d averaged, %0d accepted into history)",
               sent_count, checked_count, avg_count, accepted_count);
      $display("%0d window writes, %0d input stall cycles, %0d mismatches",
               window_writes, full_stall_cycles, error_count);
      if (error_count == 0) begin
         $display("ntc_temperature_outlier_filter verification clean");
      end else begin
         $display("ntc_temperature_outlier_filter verification failed");
      end
      $finish;
   end

endmodule
